@@ rtl/core/cpht_pkg.sv @@
// Shared types, widths and codes for the convex polygon hit test block.
package cpht_pkg;

  // Defaults for the top-level parameters.
  localparam int MAX_VERTICES_DEF = 64;
  localparam int FRAC_BITS_DEF    = 4;

  // Fixed field widths of the transaction payload.
  localparam int CMD_W   = 1;
  localparam int IDX_W   = 6;
  localparam int VERT_W  = 16;
  localparam int PNT_W   = 12;
  localparam int COUNT_W = 7;

  // Vertex store word: y in the upper half, x in the lower half.
  localparam int WORD_W = 2 * VERT_W;

  // Edge vector components are differences of two vertex coordinates.
  localparam int EDGE_W = VERT_W + 1;

  // Fewest vertices a polygon may have, and the vertex count after reset.
  localparam int             MIN_VERTICES = 3;
  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MIN_VERTICES);

  // Configuration space: one register on a 32-bit data bus, byte-addressed.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_VERTEX_COUNT = '0;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    OP_LOAD = 1'b0,
    OP_TEST = 1'b1
  } op_e;

  // One classified transaction as it waits in the queue.
  typedef struct packed {
    op_e                      op;
    logic                     slot_ok;
    logic [IDX_W-1:0]         vertex_index;
    logic signed [VERT_W-1:0] vertex_x;
    logic signed [VERT_W-1:0] vertex_y;
    logic signed [PNT_W-1:0]  point_x;
    logic signed [PNT_W-1:0]  point_y;
  } item_t;

endpackage

@@ rtl/core/cpht_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module cpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/cpht_front.sv @@
// Front end: accepts transactions, classifies them and queues them for the back end.
module cpht_front #(
  parameter int MAX_VERTICES = cpht_pkg::MAX_VERTICES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cpht_pkg::CMD_W-1:0]          cmd_i,
  input  logic [cpht_pkg::IDX_W-1:0]          vertex_index_i,
  input  logic signed [cpht_pkg::VERT_W-1:0]  vertex_x_i,
  input  logic signed [cpht_pkg::VERT_W-1:0]  vertex_y_i,
  input  logic signed [cpht_pkg::PNT_W-1:0]   point_x_i,
  input  logic signed [cpht_pkg::PNT_W-1:0]   point_y_i,
  output logic                                item_valid_o,
  input  logic                                item_ready_i,
  output cpht_pkg::item_t                     item_o
);

  cpht_pkg::item_t                    entry_d;
  cpht_pkg::item_t                    queue_q [cpht_pkg::QUEUE_DEPTH];
  logic [cpht_pkg::QPTR_W-1:0]        wr_ptr_q;
  logic [cpht_pkg::QPTR_W-1:0]        rd_ptr_q;
  logic [cpht_pkg::QCNT_W-1:0]        count_q;
  logic                               push;
  logic                               pop;

  // Classify: decode the command and check the slot against the table size.
  always_comb begin
    entry_d              = '0;
    entry_d.op           = (cmd_i == cpht_pkg::OP_TEST) ? cpht_pkg::OP_TEST
                                                        : cpht_pkg::OP_LOAD;
    entry_d.slot_ok      = (32'(vertex_index_i) < MAX_VERTICES);
    entry_d.vertex_index = vertex_index_i;
    entry_d.vertex_x     = vertex_x_i;
    entry_d.vertex_y     = vertex_y_i;
    entry_d.point_x      = point_x_i;
    entry_d.point_y      = point_y_i;
  end

  assign in_ready_o   = (count_q != cpht_pkg::QCNT_W'(cpht_pkg::QUEUE_DEPTH));
  assign item_valid_o = (count_q != '0);
  assign item_o       = queue_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= cpht_pkg::QPTR_W'(wr_ptr_q + 1'b1);
      end
      if (pop) begin
        rd_ptr_q <= cpht_pkg::QPTR_W'(rd_ptr_q + 1'b1);
      end
      if (push && !pop) begin
        count_q <= cpht_pkg::QCNT_W'(count_q + 1'b1);
      end else if (pop && !push) begin
        count_q <= cpht_pkg::QCNT_W'(count_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= entry_d;
    end
  end

endmodule

@@ rtl/core/cpht_back.sv @@
// Back end: vertex store writes and the edge-by-edge cross-product sequencer.
module cpht_back #(
  parameter int MAX_VERTICES = cpht_pkg::MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = cpht_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [cpht_pkg::COUNT_W-1:0]    vertex_count_i,
  input  logic                            item_valid_i,
  output logic                            item_ready_o,
  input  cpht_pkg::item_t                 item_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            inside_res_o
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int PW = cpht_pkg::PNT_W + FRAC_BITS;
  localparam int DW = ((PW > cpht_pkg::VERT_W) ? PW : cpht_pkg::VERT_W) + 1;
  localparam int EW = cpht_pkg::EDGE_W;
  localparam int MW = EW + DW;
  localparam int ZW = MW + 1;
  localparam int VW = cpht_pkg::VERT_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

  state_e                     state_q;
  logic [CW-1:0]              n_q;
  logic [CW-1:0]              n_d;
  logic [CW-1:0]              rd_cnt_q;
  logic                       rd_v_q;
  logic                       have_prev_q;
  logic                       s1_v_q;
  logic                       s2_v_q;
  logic                       outside_q;
  logic                       out_valid_q;
  logic                       inside_q;

  logic signed [PW-1:0]       qx_q;
  logic signed [PW-1:0]       qy_q;
  logic signed [PW-1:0]       qx_d;
  logic signed [PW-1:0]       qy_d;
  logic [cpht_pkg::WORD_W-1:0] prev_q;
  logic [cpht_pkg::WORD_W-1:0] rdata;
  logic signed [EW-1:0]       ex_q;
  logic signed [EW-1:0]       ey_q;
  logic signed [DW-1:0]       px_q;
  logic signed [DW-1:0]       py_q;
  logic signed [MW-1:0]       p1_q;
  logic signed [MW-1:0]       p2_q;
  logic signed [ZW-1:0]       z;
  logic                       z_pos;

  logic signed [VW-1:0]       prev_x;
  logic signed [VW-1:0]       prev_y;
  logic signed [VW-1:0]       cur_x;
  logic signed [VW-1:0]       cur_y;

  logic                       start;
  logic                       finish;
  logic                       we;
  logic                       rd_en;
  logic [AW-1:0]              raddr;
  logic [AW-1:0]              waddr;
  logic                       pipe_empty;

  assign item_ready_o = (state_q == ST_IDLE);
  assign start = item_valid_i && (state_q == ST_IDLE) && (item_i.op == cpht_pkg::OP_TEST);
  assign we    = item_valid_i && (state_q == ST_IDLE) && (item_i.op == cpht_pkg::OP_LOAD)
                 && item_i.slot_ok;
  assign waddr = AW'(item_i.vertex_index);
  assign rd_en = (state_q == ST_RUN);
  // The last read of a test wraps back to vertex 0 for the closing edge.
  assign raddr = (rd_cnt_q == n_q) ? '0 : rd_cnt_q[AW-1:0];
  assign pipe_empty = !rd_v_q && !s1_v_q && !s2_v_q;
  // The result is handed over once the pipeline is empty and the output is free.
  assign finish = (state_q == ST_DRAIN) && pipe_empty && (!out_valid_q || out_ready_i);

  // Clamp the vertex count into the range the table supports.
  always_comb begin
    if (vertex_count_i < cpht_pkg::COUNT_W'(cpht_pkg::MIN_VERTICES)) begin
      n_d = CW'(cpht_pkg::MIN_VERTICES);
    end else if (32'(vertex_count_i) > MAX_VERTICES) begin
      n_d = CW'(MAX_VERTICES);
    end else begin
      n_d = CW'(vertex_count_i);
    end
  end

  assign qx_d = PW'(item_i.point_x) <<< FRAC_BITS;
  assign qy_d = PW'(item_i.point_y) <<< FRAC_BITS;

  cpht_ram #(
    .WIDTH (cpht_pkg::WORD_W),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i ({item_i.vertex_y, item_i.vertex_x}),
    .re_i    (rd_en),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign prev_x = prev_q[VW-1:0];
  assign prev_y = prev_q[2*VW-1:VW];
  assign cur_x  = rdata[VW-1:0];
  assign cur_y  = rdata[2*VW-1:VW];

  assign z     = ZW'(p1_q) - ZW'(p2_q);
  assign z_pos = !z[ZW-1] && (z != '0);

  // Sequencer state, pipeline valids and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      rd_cnt_q    <= '0;
      rd_v_q      <= 1'b0;
      have_prev_q <= 1'b0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      outside_q   <= 1'b0;
      out_valid_q <= 1'b0;
      inside_q    <= 1'b0;
    end else begin
      rd_v_q <= rd_en;
      s1_v_q <= rd_v_q && have_prev_q;
      s2_v_q <= s1_v_q;
      if (start) begin
        have_prev_q <= 1'b0;
      end else if (rd_v_q) begin
        have_prev_q <= 1'b1;
      end
      if (start) begin
        outside_q <= 1'b0;
      end else if (s2_v_q && z_pos) begin
        outside_q <= 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q  <= ST_RUN;
            n_q      <= n_d;
            rd_cnt_q <= '0;
          end
        end
        ST_RUN: begin
          rd_cnt_q <= CW'(rd_cnt_q + 1'b1);
          if (rd_cnt_q == n_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (finish) begin
            inside_q <= !outside_q;
            state_q  <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath: differences, then products, then the sign check above.
  always_ff @(posedge clk_i) begin
    if (start) begin
      qx_q <= qx_d;
      qy_q <= qy_d;
    end
    if (rd_v_q) begin
      prev_q <= rdata;
    end
    ex_q <= EW'(cur_x) - EW'(prev_x);
    ey_q <= EW'(cur_y) - EW'(prev_y);
    px_q <= DW'(qx_q) - DW'(prev_x);
    py_q <= DW'(qy_q) - DW'(prev_y);
    p1_q <= MW'(ex_q) * MW'(py_q);
    p2_q <= MW'(ey_q) * MW'(px_q);
  end

  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

endmodule

@@ rtl/core/convex_polygon_hit_test.sv @@
// Top level of the convex polygon hit test block with its configuration register.
// The block holds up to MAX_VERTICES polygon vertices in signed fixed point with
// FRAC_BITS fraction bits and answers whether a pixel point lies inside the convex
// polygon they form. A transaction with cmd 0 loads one vertex into a table slot and
// produces no result; a transaction with cmd 1 tests a point and produces one
// inside_res transaction, 1 when no edge cross product is positive (points on an edge
// count as inside). Results leave in the order the tests arrived. A two-entry queue
// sits between the input side and the execution side, so up to two transactions are
// still accepted while a test runs. A load is written to the vertex store in the same
// cycle it leaves the queue. For a test with n vertices in use, the vertex store has
// one read port and is read once per cycle, vertex 0 through n-1 and then vertex 0
// again for the closing edge, and one shared cross-product unit handles one edge per
// cycle behind it with a pipeline of differences, products and a sign check. A result
// that is not taken holds the next test at the end of its run. The vertex count
// register lies at byte address 0 of the APB-style port, reads back its value and is
// used clamped to 3..MAX_VERTICES; it must only be written while no transaction is
// in flight. A test must only use slots that have been loaded since reset, because
// the vertex store is not cleared.
module convex_polygon_hit_test #(
  parameter int MAX_VERTICES = cpht_pkg::MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = cpht_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // APB-style configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [cpht_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [cpht_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [cpht_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  // Input channel.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [cpht_pkg::CMD_W-1:0]           cmd_i,
  input  logic [cpht_pkg::IDX_W-1:0]           vertex_index_i,
  input  logic signed [cpht_pkg::VERT_W-1:0]   vertex_x_i,
  input  logic signed [cpht_pkg::VERT_W-1:0]   vertex_y_i,
  input  logic signed [cpht_pkg::PNT_W-1:0]    point_x_i,
  input  logic signed [cpht_pkg::PNT_W-1:0]    point_y_i,
  // Result channel.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 inside_res_o
);

  logic [cpht_pkg::COUNT_W-1:0]   vertex_count_q;
  logic [cpht_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           cfg_write;
  logic                           item_valid;
  logic                           item_ready;
  cpht_pkg::item_t                item;

  // The register index is the word address; the write lands in the access phase.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[cpht_pkg::APB_ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= cpht_pkg::COUNT_RESET;
    end else begin
      if (cfg_write && (reg_idx == cpht_pkg::REG_VERTEX_COUNT)) begin
        vertex_count_q <= pwdata[cpht_pkg::COUNT_W-1:0];
      end
    end
  end

  // Reads of unmapped addresses return zero.
  always_comb begin
    prdata = '0;
    if (reg_idx == cpht_pkg::REG_VERTEX_COUNT) begin
      prdata = cpht_pkg::APB_DATA_W'(vertex_count_q);
    end
  end

  // Front end: accepts and classifies transactions into the queue.
  cpht_front #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .vertex_index_i (vertex_index_i),
    .vertex_x_i     (vertex_x_i),
    .vertex_y_i     (vertex_y_i),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .item_valid_o   (item_valid),
    .item_ready_i   (item_ready),
    .item_o         (item)
  );

  // Back end: writes the vertex store and walks the edges of each test.
  cpht_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .FRAC_BITS    (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vertex_count_i (vertex_count_q),
    .item_valid_i   (item_valid),
    .item_ready_o   (item_ready),
    .item_i         (item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .inside_res_o   (inside_res_o)
  );

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the convex polygon hit test block.
module tb;
  import cpht_pkg::*;

  localparam int MAX_V           = MAX_VERTICES_DEF;
  localparam int FRAC            = FRAC_BITS_DEF;
  localparam int NUM_PHASES      = 9;
  localparam int ITEMS_PER_PHASE = 128;
  // A load can still be queued for the back end after the last test result.
  localparam int SETTLE_CYCLES   = 12;
  // Wait past the longest test for stray results.
  localparam int TAIL_CYCLES     = 80;
  localparam real TWO_PI         = 6.283185307179586;

  // The second register index decodes to nothing, so writes there must be dropped.
  localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(1);

  // Vertex count written at the start of each phase; phase 0 runs on the reset value.
  localparam logic [COUNT_W-1:0] PHASE_COUNT [NUM_PHASES] = '{
    7'd3, 7'd127, 7'd0, 7'd5, 7'd64, 7'd2, 7'd65, 7'd12, 7'd3
  };

  typedef struct packed {
    logic signed [VERT_W-1:0] y;
    logic signed [VERT_W-1:0] x;
  } vertex_t;

  // Keeps a private copy of the vertex table and the count register, predicts the
  // inside flag of every accepted test and matches it against the result stream.
  class hit_scoreboard;
    vertex_t            vertex_table [MAX_V];
    logic [COUNT_W-1:0] count_reg;
    bit                 inside_queue [$];
    int                 failures;

    function new();
      count_reg = COUNT_RESET;
      failures  = 0;
    endfunction

    function void set_count(logic [COUNT_W-1:0] value);
      count_reg = value;
    endfunction

    // Counts below three act as three and counts above the table act as the table size.
    function int active_vertices();
      int n;
      n = count_reg;
      if (n < MIN_VERTICES) n = MIN_VERTICES;
      if (n > MAX_V) n = MAX_V;
      return n;
    endfunction

    // The point is scaled to the vertex format. Any edge with a positive cross
    // product puts it outside; a zero product keeps it inside.
    function bit point_inside(logic signed [PNT_W-1:0] qx, logic signed [PNT_W-1:0] qy);
      int     n, a, b;
      longint px, py, ax, ay, ex, ey;
      n  = active_vertices();
      px = longint'(qx) * (longint'(1) << FRAC);
      py = longint'(qy) * (longint'(1) << FRAC);
      for (a = 0; a < n; a++) begin
        b  = (a + 1 == n) ? 0 : a + 1;
        ax = longint'(vertex_table[a].x);
        ay = longint'(vertex_table[a].y);
        ex = longint'(vertex_table[b].x) - ax;
        ey = longint'(vertex_table[b].y) - ay;
        if (ex * (py - ay) - ey * (px - ax) > 0) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void note_item(op_e op, logic [IDX_W-1:0] idx,
                            logic signed [VERT_W-1:0] x, logic signed [VERT_W-1:0] y,
                            logic signed [PNT_W-1:0] qx, logic signed [PNT_W-1:0] qy);
      if (op == OP_LOAD) begin
        if (idx < MAX_V) begin
          vertex_table[idx].x = x;
          vertex_table[idx].y = y;
        end
      end else begin
        inside_queue.insert(inside_queue.size(), point_inside(qx, qy));
      end
    endfunction

    function void compare(string what, logic [APB_DATA_W-1:0] expected_val,
                          logic [APB_DATA_W-1:0] actual_val);
      if (actual_val !== expected_val) begin
        failures++;
        if (failures <= 10)
          $display("mismatch on %s: expected %0d, got %0d", what, expected_val, actual_val);
      end
    endfunction

    function void check_result(logic res);
      bit expected_flag;
      if (inside_queue.size() == 0) begin
        failures++;
        if (failures <= 10) $display("inside_res transaction with no test outstanding");
      end else begin
        expected_flag = inside_queue.pop_front();
        compare("inside_res", APB_DATA_W'(expected_flag), APB_DATA_W'(res));
      end
    endfunction

    function int pending();
      return inside_queue.size();
    endfunction
  endclass

  logic                     clk          = 1'b0;
  logic                     rst_n        = 1'b0;
  logic                     psel         = 1'b0;
  logic                     penable      = 1'b0;
  logic                     pwrite       = 1'b0;
  logic [APB_ADDR_W-1:0]    paddr        = '0;
  logic [APB_DATA_W-1:0]    pwdata       = '0;
  logic [APB_DATA_W-1:0]    prdata;
  logic                     pready;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  op_e                      cmd          = OP_LOAD;
  logic [IDX_W-1:0]         vertex_index = '0;
  logic signed [VERT_W-1:0] vertex_x     = '0;
  logic signed [VERT_W-1:0] vertex_y     = '0;
  logic signed [PNT_W-1:0]  point_x      = '0;
  logic signed [PNT_W-1:0]  point_y      = '0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic                     inside_res;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int items_sent  = 0;

  hit_scoreboard sb;

  // The polygon most recently loaded, used to aim test points at it.
  logic signed [VERT_W-1:0] poly_x [MAX_V];
  logic signed [VERT_W-1:0] poly_y [MAX_V];
  real                      poly_cx, poly_cy, poly_r;
  int                       poly_n;

  convex_polygon_hit_test uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .cmd_i         (cmd),
    .vertex_index_i(vertex_index),
    .vertex_x_i    (vertex_x),
    .vertex_y_i    (vertex_y),
    .point_x_i     (point_x),
    .point_y_i     (point_y),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .inside_res_o  (inside_res)
  );

  always #4 clk = ~clk;

  // Result side: a transaction completes at an edge with valid and ready both high.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(inside_res);
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  function automatic longint saturate(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Called just after a rising edge. Valid stays high after acceptance, so the
  // caller either presents the next transaction or drops valid in the next step.
  task automatic send_item(input op_e op, input logic [IDX_W-1:0] idx,
                           input logic signed [VERT_W-1:0] x,
                           input logic signed [VERT_W-1:0] y,
                           input logic signed [PNT_W-1:0] qx,
                           input logic signed [PNT_W-1:0] qy);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    cmd          <= op;
    vertex_index <= idx;
    vertex_x     <= x;
    vertex_y     <= y;
    point_x      <= qx;
    point_y      <= qy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(op, idx, x, y, qx, qy);
    items_sent++;
  endtask

  // The fields a command does not use carry random values.
  task automatic load_vertex(input logic [IDX_W-1:0] idx, input logic signed [VERT_W-1:0] x,
                             input logic signed [VERT_W-1:0] y);
    send_item(OP_LOAD, idx, x, y, PNT_W'($urandom()), PNT_W'($urandom()));
  endtask

  task automatic test_point(input logic signed [PNT_W-1:0] qx,
                            input logic signed [PNT_W-1:0] qy);
    send_item(OP_TEST, IDX_W'($urandom()), VERT_W'($urandom()), VERT_W'($urandom()), qx, qy);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes one register, then reads the vertex count back and checks it.
  task automatic write_and_check(input logic [REG_IDX_W-1:0] idx,
                                 input logic [APB_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_VERTEX_COUNT) sb.set_count(value[COUNT_W-1:0]);
    @(posedge clk);
    psel    <= 1'b1;
    paddr   <= {REG_VERTEX_COUNT, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.compare("vertex_count readback", APB_DATA_W'(sb.count_reg), prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Builds a polygon with vertices on an ellipse, mostly in the winding that
  // makes its interior read as inside, sometimes snapped to whole pixels so
  // that points can land exactly on vertices and edges.
  task automatic load_polygon();
    int     n, k, slot;
    real    cx, cy, rx, ry, base, arc, ang, fx, fy, dir;
    bit     snap, ascending;
    longint vx, vy;
    n  = sb.active_vertices();
    cx = $urandom_range(0, 4000) - 2000.0;
    cy = $urandom_range(0, 4000) - 2000.0;
    case ($urandom_range(9))
      0, 1, 2, 3, 4: rx = $urandom_range(1, 40);
      5, 6, 7, 8:    rx = $urandom_range(40, 400);
      default:       rx = $urandom_range(400, 2000);
    endcase
    ry        = rx * (0.5 + $urandom_range(0, 100) / 100.0);
    snap      = $urandom_range(1);
    ascending = $urandom_range(1);
    dir       = ($urandom_range(9) == 0) ? 1.0 : -1.0;
    base      = $urandom_range(0, 999) * TWO_PI / 1000.0;
    arc       = TWO_PI / n;
    for (k = 0; k < n; k++) begin
      ang = base + dir * k * arc + ($urandom_range(0, 60) - 30.0) * arc / 100.0;
      fx  = cx + rx * $cos(ang);
      fy  = cy + ry * $sin(ang);
      if (snap) begin
        fx = real'(longint'(fx));
        fy = real'(longint'(fy));
      end
      vx = longint'(fx * (1 << FRAC));
      vy = longint'(fy * (1 << FRAC));
      poly_x[k] = VERT_W'(saturate(vx, -32768, 32767));
      poly_y[k] = VERT_W'(saturate(vy, -32768, 32767));
    end
    poly_cx = cx;
    poly_cy = cy;
    poly_r  = (rx > ry) ? rx : ry;
    poly_n  = n;
    for (k = 0; k < n; k++) begin
      slot = ascending ? k : n - 1 - k;
      load_vertex(IDX_W'(slot), poly_x[slot], poly_y[slot]);
    end
  endtask

  // Mostly points around the current polygon, with some on or beside its vertices,
  // some anywhere, and some stray loads that bend the shape.
  task automatic test_burst();
    int     len, k, pick, v;
    longint qx, qy;
    real    span;
    len = $urandom_range(6, 40);
    for (k = 0; k < len; k++) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        load_vertex(IDX_W'($urandom()), VERT_W'($urandom()), VERT_W'($urandom()));
      end else if (pick < 15) begin
        test_point(PNT_W'($urandom()), PNT_W'($urandom()));
      end else begin
        if (pick < 22) begin
          v  = $urandom_range(poly_n - 1);
          qx = (longint'(poly_x[v]) >>> FRAC) + int'($urandom_range(2)) - 1;
          qy = (longint'(poly_y[v]) >>> FRAC) + int'($urandom_range(2)) - 1;
        end else begin
          span = poly_r * 1.3 + 2.0;
          qx = longint'(poly_cx + ($urandom_range(0, 2000) - 1000.0) / 1000.0 * span);
          qy = longint'(poly_cy + ($urandom_range(0, 2000) - 1000.0) / 1000.0 * span);
        end
        test_point(PNT_W'(saturate(qx, -2048, 2047)), PNT_W'(saturate(qy, -2048, 2047)));
      end
    end
  endtask

  initial begin
    logic [APB_DATA_W-1:0] cfg;
    int                    phase;
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase / 3)
        0: begin
          tx_idle_pct = 34;
          rx_idle_pct = 72;
        end
        1: begin
          tx_idle_pct = 72;
          rx_idle_pct = 34;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase

      if (phase > 0) begin
        // The count may only change with nothing in flight.
        wait_idle();
        cfg = $urandom();
        cfg[COUNT_W-1:0] = PHASE_COUNT[phase];
        write_and_check(REG_VERTEX_COUNT, cfg);
        if (phase == 4) write_and_check(REG_SPARE, $urandom());
      end

      if (phase == 0) begin
        // Right triangle at whole pixels: interior, vertex, both legs, hypotenuse,
        // one pixel past an edge and the four corners of the point range.
        load_vertex(0, 0, 0);
        load_vertex(1, 0, 1600);
        load_vertex(2, 1600, 0);
        test_point(10, 10);
        test_point(0, 0);
        test_point(0, 50);
        test_point(50, 0);
        test_point(50, 50);
        test_point(-1, 0);
        test_point(51, 50);
        test_point(-2048, -2048);
        test_point(2047, 2047);
        test_point(-2048, 2047);
        test_point(2047, -2048);
        // Same winding stretched to the limits of the vertex format.
        load_vertex(0, -32768, -32768);
        load_vertex(1, -32768, 32767);
        load_vertex(2, 32767, -32768);
        test_point(-1000, -1000);
        test_point(0, 0);
        test_point(-2048, -2048);
        test_point(2047, 2047);
      end

      while (items_sent < (phase + 1) * ITEMS_PER_PHASE) begin
        load_polygon();
        test_burst();
        if ($urandom_range(19) == 0) wait_idle();
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
